@@ sv/mpsm_pkg.sv @@
package mpsm_pkg;

  // input word kinds, carried in s_tuser
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_LAST  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_ALT_COUNT   = 3'd0;
  localparam logic [2:0] REG_ALT_LENGTHS = 3'd1;
  localparam logic [2:0] REG_ANCHORED    = 3'd2;
  localparam logic [2:0] REG_PATTERN_0   = 3'd3;
  localparam logic [2:0] REG_PATTERN_1   = 3'd4;
  localparam logic [2:0] REG_PATTERN_2   = 3'd5;
  localparam logic [2:0] REG_PATTERN_3   = 3'd6;

  localparam int ALT_SLOTS   = 4;
  localparam int LEN_FIELD_W = 4;
  localparam int BYTES_PER_WORD = 8;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [2:0]                     alt_count;
    logic [ALT_SLOTS*LEN_FIELD_W-1:0] alt_lengths;
    logic [ALT_SLOTS-1:0]           anchored;
    logic [ALT_SLOTS-1:0][63:0]     patterns;
  } mpsm_cfg_t;

  // classified word handed from front to back
  typedef struct packed {
    logic       last;
    logic       empty;
    logic [7:0] ch;
  } mpsm_item_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) begin
      return c + 8'h20;
    end
    return c;
  endfunction

endpackage

@@ sv/mpsm_front.sv @@
module mpsm_front
  import mpsm_pkg::*;
(
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,  // text_byte
  input  logic [1:0] s_tuser,  // kind
  output logic       q_valid,
  input  logic       q_ready,
  output mpsm_item_t q_item
);

  assign s_tready = q_ready;

  // unknown kind is taken and dropped
  always_comb begin
    q_item.ch    = fold_case(s_tdata);
    q_item.last  = 1'b0;
    q_item.empty = 1'b0;
    q_valid      = 1'b0;
    case (s_tuser)
      KIND_BYTE: begin
        q_valid = s_tvalid;
      end
      KIND_LAST: begin
        q_valid     = s_tvalid;
        q_item.last = 1'b1;
      end
      KIND_EMPTY: begin
        q_valid      = s_tvalid;
        q_item.empty = 1'b1;
      end
      default: begin
        q_valid = 1'b0;
      end
    endcase
  end

endmodule

@@ sv/mpsm_queue.sv @@
module mpsm_queue
  import mpsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  mpsm_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output mpsm_item_t pop_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  mpsm_item_t       slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

@@ sv/mpsm_back.sv @@
module mpsm_back
  import mpsm_pkg::*;
#(
  parameter int MAX_ALTERNATIVES = 4,
  parameter int MAX_PATTERN_LEN  = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  mpsm_cfg_t  cfg,
  input  logic       q_valid,
  output logic       q_ready,
  input  mpsm_item_t q_item,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata
);

  localparam int NA    = MAX_ALTERNATIVES;
  localparam int NL    = MAX_PATTERN_LEN;
  localparam int POS_W = $clog2(NL + 1);

  logic [NL-1:0]          pm       [NA];
  logic [NL-1:0]          pm_next  [NA];
  logic [NA-1:0]          prefix_ok;
  logic [NA-1:0]          prefix_ok_next;
  logic [POS_W-1:0]       pos;
  logic [POS_W-1:0]       pos_next;
  logic                   found;
  logic                   found_next;
  logic                   matched;
  logic                   decision;
  logic                   pop;
  logic                   any_empty_alt;
  logic                   any_anchor_ok;
  logic [LEN_FIELD_W-1:0] alt_len  [NA];

  assign q_ready = !m_tvalid || m_tready;
  assign pop     = q_valid && q_ready;
  assign m_tdata = {7'd0, matched};

  // one step per alternative, all in parallel: shift-and, or prefix check if anchored
  always_comb begin
    logic [LEN_FIELD_W-1:0] fld;
    logic [NL-1:0]          eq;
    logic [NL-1:0]          sel;
    logic [NL-1:0]          upd;
    logic [7:0]             pbyte;
    logic                   act;
    logic                   mism;
    found_next    = found;
    any_empty_alt = 1'b0;
    any_anchor_ok = 1'b0;
    pos_next      = (pos == POS_W'(NL)) ? pos : pos + POS_W'(1);
    for (int a = 0; a < NA; a++) begin
      fld        = cfg.alt_lengths[a*LEN_FIELD_W +: LEN_FIELD_W];
      alt_len[a] = (fld > LEN_FIELD_W'(NL)) ? LEN_FIELD_W'(NL) : fld;
      act        = (cfg.alt_count > 3'(a));
      eq         = '0;
      sel        = '0;
      mism       = 1'b0;
      for (int k = 0; k < NL; k++) begin
        pbyte  = fold_case(cfg.patterns[a][k*8 +: 8]);
        eq[k]  = (LEN_FIELD_W'(k) < alt_len[a]) && (pbyte == q_item.ch);
        sel[k] = (alt_len[a] == LEN_FIELD_W'(k + 1));
        if (LEN_FIELD_W'(pos) == LEN_FIELD_W'(k) && LEN_FIELD_W'(k) < alt_len[a] &&
            pbyte != q_item.ch) begin
          mism = 1'b1;
        end
      end
      upd               = ((pm[a] << 1) | NL'(1)) & eq;
      pm_next[a]        = pm[a];
      prefix_ok_next[a] = prefix_ok[a];
      if (act) begin
        if (cfg.anchored[a]) begin
          if (mism) begin
            prefix_ok_next[a] = 1'b0;
          end
        end else if (alt_len[a] != '0) begin
          pm_next[a] = upd;
          if ((upd & sel) != '0) begin
            found_next = 1'b1;
          end
        end
        if (alt_len[a] == '0) begin
          any_empty_alt = 1'b1;
        end
        if (cfg.anchored[a] && prefix_ok_next[a] &&
            LEN_FIELD_W'(pos_next) >= alt_len[a]) begin
          any_anchor_ok = 1'b1;
        end
      end
    end
    if (q_item.empty) begin
      decision = any_empty_alt;
    end else begin
      decision = found_next || any_empty_alt || any_anchor_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NA; a++) begin
        pm[a] <= '0;
      end
      prefix_ok <= '1;
      pos       <= '0;
      found     <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (pop) begin
        if (q_item.last || q_item.empty) begin
          for (int a = 0; a < NA; a++) begin
            pm[a] <= '0;
          end
          prefix_ok <= '1;
          pos       <= '0;
          found     <= 1'b0;
        end else begin
          pm        <= pm_next;
          prefix_ok <= prefix_ok_next;
          pos       <= pos_next;
          found     <= found_next;
        end
      end
      if (pop && (q_item.last || q_item.empty)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (q_item.last || q_item.empty)) begin
      matched <= decision;
    end
  end

endmodule

@@ sv/multi_pattern_substring_matcher.sv @@
// a final or empty-string word is written into the queue, then popped by the back stage, which
// registers its result word; while a result word stalls, the back stage pops nothing
// throughput: one word per cycle unless a result stalls, set by the back-stage shift-and update
// a stalled result holds the back stage; the front keeps taking words until the queue fills
// reset: synchronous, active high; clears configuration to zero, per-string state and queue
// no clearing pass after reset: the block takes words as soon as rst falls
module multi_pattern_substring_matcher
  import mpsm_pkg::*;
#(
  parameter int MAX_ALTERNATIVES = 4,
  parameter int MAX_PATTERN_LEN  = 8
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // text words in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic [1:0]  s_tuser,   // [1:0] kind
  // result words out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [0] matched, [7:1] zero
);

  mpsm_cfg_t  cfg;
  logic       f_valid;
  logic       f_ready;
  mpsm_item_t f_item;
  logic       b_valid;
  logic       b_ready;
  mpsm_item_t b_item;

  // configuration registers: to be written only between strings; the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ALT_COUNT:   cfg.alt_count   <= cfg_data[2:0];
        REG_ALT_LENGTHS: cfg.alt_lengths <= cfg_data[ALT_SLOTS*LEN_FIELD_W-1:0];
        REG_ANCHORED:    cfg.anchored    <= cfg_data[ALT_SLOTS-1:0];
        REG_PATTERN_0:   cfg.patterns[0] <= cfg_data;
        REG_PATTERN_1:   cfg.patterns[1] <= cfg_data;
        REG_PATTERN_2:   cfg.patterns[2] <= cfg_data;
        REG_PATTERN_3:   cfg.patterns[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // front: case folding and word classification
  mpsm_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_item   (f_item)
  );

  // short queue decouples the input side from a stalled result
  mpsm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_item   (b_item)
  );

  // back: shift-and matching state and the registered result word
  mpsm_back #(
    .MAX_ALTERNATIVES (MAX_ALTERNATIVES),
    .MAX_PATTERN_LEN  (MAX_PATTERN_LEN)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (b_valid),
    .q_ready  (b_ready),
    .q_item   (b_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

@@ sv/mpsm_checker.sv @@
module mpsm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // only the matched bit is ever set
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:1] == 7'd0)
    else $error("padding bits of result word not zero");

  // reset empties the output register
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result word valid right after reset");

  // reset empties the queue, so input is ready at once
  assert property (@(posedge clk)
    rst |=> s_tready)
    else $error("input not ready right after reset");

endmodule

bind multi_pattern_substring_matcher mpsm_checker u_checker (.*);

@@ sim/tb_multi_pattern_substring_matcher.sv @@
`timescale 1ns / 100ps

module tb_multi_pattern_substring_matcher;
  import mpsm_pkg::*;

  // kind 3 has no name in the package; the block must drop such words
  localparam logic [1:0] KIND_RESERVED = 2'd3;

  localparam int MAX_ALTS           = 4;
  localparam int MAX_LEN            = 8;
  localparam int STALL_LIMIT        = 4000;  // cycles with no word moving on either side
  localparam int LONG_HOLD          = 120;   // receiver back-pressure burst
  localparam int SETTINGS_PER_PHASE = 5;
  localparam int WORDS_PER_SETTING  = 100;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
  } text_word_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;   // [7:0] text_byte
  logic [1:0]  s_tuser   = '0;   // [1:0] kind
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;          // [0] matched, [7:1] zero

  multi_pattern_substring_matcher uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // shadow copy of the configuration registers
  logic [2:0]  alt_count_r;
  logic [15:0] alt_len_r;
  logic [3:0]  anchored_r;
  logic [63:0] pattern_r [MAX_ALTS];

  // per-string matcher state
  logic [7:0]  shift_bits [MAX_ALTS];  // shift-and partial match vector per alternative
  logic [3:0]  prefix_ok;              // anchored alternative still agrees with text start
  logic [3:0]  position;               // bytes seen, saturating
  logic        found;                  // some unanchored alternative has hit

  text_word_t  word_q[$];              // text words waiting to be sent
  bit          pending_verdicts[$];    // match verdicts the block still owes

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_toggle   = 1'b0;            // flipped to ask the receiver for a long hold
  bit hold_seen     = 1'b0;
  int hold_left     = 0;

  int mismatches      = 0;
  int words_taken     = 0;
  int strings_checked = 0;
  int matches_seen    = 0;
  int settings_used   = 0;
  int quiet_cycles    = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) begin
      return c | 8'h20;
    end
    return c;
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return ((c | 8'h20) >= 8'h61) && ((c | 8'h20) <= 8'h7a);
  endfunction

  // length fields above the pattern capacity clamp to it
  function automatic int eff_len(input int a);
    int n;
    n = int'(alt_len_r[4*a +: 4]);
    return (n > MAX_LEN) ? MAX_LEN : n;
  endfunction

  function automatic logic [7:0] pat_char(input int a, input int k);
    return to_lower(pattern_r[a][8*k +: 8]);
  endfunction

  // counts above the slot count clamp to it
  function automatic int live_alts();
    return (alt_count_r > MAX_ALTS) ? MAX_ALTS : int'(alt_count_r);
  endfunction

  task automatic restart_string();
    for (int a = 0; a < MAX_ALTS; a++) begin
      shift_bits[a] = '0;
    end
    prefix_ok = '1;
    position  = '0;
    found     = 1'b0;
  endtask

  task automatic advance_on_char(input logic [7:0] raw);
    logic [7:0] c;
    logic [7:0] hits;
    int         len;
    c = to_lower(raw);
    for (int a = 0; a < live_alts(); a++) begin
      len = eff_len(a);
      if (anchored_r[a]) begin
        // anchored: compare only while still inside the pattern
        if (position < len && pat_char(a, int'(position)) != c) begin
          prefix_ok[a] = 1'b0;
        end
      end else if (len > 0) begin
        hits = '0;
        for (int k = 0; k < len; k++) begin
          if (pat_char(a, k) == c) begin
            hits[k] = 1'b1;
          end
        end
        shift_bits[a] = {shift_bits[a][6:0], 1'b1} & hits;
        if (shift_bits[a][len-1]) begin
          found = 1'b1;
        end
      end
    end
    if (position < MAX_LEN) begin
      position = position + 4'd1;
    end
  endtask

  function automatic bit string_verdict();
    int len;
    if (found) begin
      return 1'b1;
    end
    for (int a = 0; a < live_alts(); a++) begin
      len = eff_len(a);
      // an empty alternative matches any string, the empty one too
      if (len == 0) begin
        return 1'b1;
      end
      if (anchored_r[a] && prefix_ok[a] && position >= len) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic predict_word(input logic [1:0] kind, input logic [7:0] ch);
    case (kind)
      KIND_BYTE: begin
        advance_on_char(ch);
      end
      KIND_LAST: begin
        advance_on_char(ch);
        pending_verdicts.push_back(string_verdict());
        restart_string();
      end
      KIND_EMPTY: begin
        restart_string();
        pending_verdicts.push_back(string_verdict());
        restart_string();
      end
      default: begin
        // reserved kind: no state change, no result
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_ALT_COUNT:   alt_count_r  = value[2:0];
      REG_ALT_LENGTHS: alt_len_r    = value[15:0];
      REG_ANCHORED:    anchored_r   = value[3:0];
      REG_PATTERN_0:   pattern_r[0] = value;
      REG_PATTERN_1:   pattern_r[1] = value;
      REG_PATTERN_2:   pattern_r[2] = value;
      REG_PATTERN_3:   pattern_r[3] = value;
      default: begin
      end
    endcase
  endtask

  task automatic apply_setting(input logic [63:0] count, input logic [63:0] lens,
                               input logic [63:0] anch, input logic [63:0] p0,
                               input logic [63:0] p1, input logic [63:0] p2,
                               input logic [63:0] p3);
    write_reg(REG_ALT_COUNT, count);
    write_reg(REG_ALT_LENGTHS, lens);
    write_reg(REG_ANCHORED, anch);
    write_reg(REG_PATTERN_0, p0);
    write_reg(REG_PATTERN_1, p1);
    write_reg(REG_PATTERN_2, p2);
    write_reg(REG_PATTERN_3, p3);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // mostly a small mixed-case alphabet so hits are common, with odd bytes mixed in
  function automatic logic [7:0] filler_char();
    int         r;
    logic [7:0] c;
    r = $urandom_range(31);
    if (r == 0) begin
      return 8'($urandom_range(255));
    end
    if (r == 1) begin
      return 8'h00;
    end
    c = 8'h61 + 8'($urandom_range(5));
    if ($urandom_range(1)) begin
      c = c ^ 8'h20;
    end
    return c;
  endfunction

  task automatic random_setting();
    logic [63:0] count_v;
    logic [63:0] lens_v;
    logic [63:0] anch_v;
    logic [63:0] pats [MAX_ALTS];
    int          r;
    r = $urandom_range(9);
    count_v = (r == 0) ? 64'd0 : (r == 1) ? 64'($urandom_range(7, 5)) :
              64'($urandom_range(4, 1));
    lens_v = '0;
    for (int a = 0; a < MAX_ALTS; a++) begin
      r = $urandom_range(15);
      lens_v[4*a +: 4] = (r == 0) ? 4'd0 : (r == 1) ? 4'($urandom_range(15, 9)) :
                         (r < 4) ? 4'($urandom_range(8, 5)) : 4'($urandom_range(5, 2));
      for (int k = 0; k < 8; k++) begin
        pats[a][8*k +: 8] = filler_char();
      end
    end
    anch_v = 64'($urandom_range(15));
    // junk above the register width must be dropped
    if ($urandom_range(1)) begin
      count_v[63:3]  = 61'({$urandom, $urandom});
      lens_v[63:16]  = 48'({$urandom, $urandom});
      anch_v[63:4]   = 60'({$urandom, $urandom});
    end
    apply_setting(count_v, lens_v, anch_v, pats[0], pats[1], pats[2], pats[3]);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic push_word(input logic [1:0] kind, input logic [7:0] ch);
    text_word_t w;
    w.kind = kind;
    w.ch   = ch;
    word_q.push_back(w);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_word((i == s.len() - 1) ? KIND_LAST : KIND_BYTE, s[i]);
    end
  endtask

  // one string, usually seeded with a (possibly damaged) copy of an alternative
  task automatic queue_string(output int words);
    logic [7:0] text [$];
    logic [7:0] c;
    int         r;
    int         n;
    int         a;
    int         len;
    int         lead;
    words = 0;
    r = $urandom_range(15);
    if (r == 0) begin
      push_word(KIND_EMPTY, 8'($urandom_range(255)));
      words = 1;
      return;
    end
    n = (r < 13) ? $urandom_range(6, 1) : $urandom_range(20, 7);
    if ($urandom_range(3) != 0) begin
      a   = $urandom_range(MAX_ALTS - 1);
      len = eff_len(a);
      if (len > 0 && $urandom_range(3) == 0) begin
        len = $urandom_range(len - 1, 0);
      end
      lead = (anchored_r[a] || $urandom_range(3) == 0) ? 0 : $urandom_range(n);
      for (int i = 0; i < lead; i++) begin
        text.push_back(filler_char());
      end
      for (int k = 0; k < len; k++) begin
        c = pattern_r[a][8*k +: 8];
        if (is_letter(c) && $urandom_range(1)) begin
          c = c ^ 8'h20;
        end
        text.push_back(c);
      end
      for (int i = lead; i < n; i++) begin
        text.push_back(filler_char());
      end
      // near miss
      if ($urandom_range(4) == 0) begin
        text[$urandom_range(text.size() - 1)] = filler_char();
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        text.push_back(filler_char());
      end
    end
    for (int i = 0; i < text.size(); i++) begin
      if ($urandom_range(39) == 0) begin
        push_word(KIND_RESERVED, 8'($urandom_range(255)));
      end
      // string cut short by an empty-string word
      if (i > 0 && $urandom_range(59) == 0) begin
        push_word(KIND_EMPTY, 8'($urandom_range(255)));
        words++;
      end
      push_word((i == text.size() - 1) ? KIND_LAST : KIND_BYTE, text[i]);
      words++;
    end
  endtask

  // block idle: nothing queued, nothing owed, then room for words with no result
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (word_q.size() != 0 || s_tvalid || pending_verdicts.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int words;
    int sent;
    alt_count_r = '0;
    alt_len_r   = '0;
    anchored_r  = '0;
    for (int a = 0; a < MAX_ALTS; a++) begin
      pattern_r[a] = '0;
    end
    restart_string();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset configuration: nothing matches, the empty string included
    @(negedge clk);
    push_word(KIND_EMPTY, 8'hff);
    push_word(KIND_RESERVED, 8'h41);
    push_word(KIND_LAST, 8'h51);
    wait_drained();

    // "abc" anywhere, "xy" at the start only
    apply_setting(64'd2, 64'h0023, 64'h2, 64'h0063_4261, 64'h7978, 64'd0, 64'd0);
    @(negedge clk);
    push_text("xAbC");                 // unanchored hit, mixed case
    push_text("XY");                   // anchored hit on exact length
    push_text("x");                    // anchored pattern longer than text
    push_word(KIND_BYTE, 8'h7a);
    push_word(KIND_RESERVED, 8'h78);   // dropped mid-string
    push_text("xy");                   // anchored pattern not at start
    push_word(KIND_EMPTY, 8'h00);      // empty text, no empty alternative
    wait_drained();

    // count above the slot count, oversize length, empty fourth alternative
    apply_setting(64'd7, 64'h012f, 64'hf, 64'hffff_ffff_ffff_ffff, 64'h4141, 64'h42, 64'd0);
    @(negedge clk);
    push_word(KIND_EMPTY, 8'h5a);
    push_text("q");
    wait_drained();

    // one alternative, length field 9 clamps to 8; zeros, high bytes and case folding
    apply_setting(64'd1, 64'hfff9, 64'd0, 64'h8000_ff7a_5a01_0041, 64'd0, 64'd0, 64'd0);
    @(negedge clk);
    push_word(KIND_BYTE, 8'hc3);
    for (int k = 0; k < 8; k++) begin
      push_word((k == 7) ? KIND_LAST : KIND_BYTE, 8'(64'h8000_ff5a_7a01_0061 >> (8 * k)));
    end
    wait_drained();

    // random part: sender gaps light / receiver heavy, then swapped, then none
    for (int p = 0; p < 3; p++) begin
      @(negedge clk);
      send_idle_pct = (p == 0) ? 8 : (p == 1) ? 77 : 0;
      recv_idle_pct = (p == 0) ? 77 : (p == 1) ? 8 : 0;
      for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
        wait_drained();
        if (p == 0 && s == 0) begin
          apply_setting('1, '1, '1, '1, '1, '1, '1);
        end else if (p == 1 && s == 0) begin
          apply_setting('0, '0, '0, '0, '0, '0, '0);
        end else begin
          random_setting();
        end
        @(negedge clk);
        sent = 0;
        while (sent < WORDS_PER_SETTING) begin
          queue_string(words);
          sent += words;
        end
        // back-pressure burst while a full load of words is waiting
        if (s == 1) begin
          hold_toggle = ~hold_toggle;
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("run covered %0d text words and %0d strings (%0d matched) over %0d settings",
             words_taken, strings_checked, matches_seen, settings_used);
    $display("gap mixes: light send/heavy receive, the reverse, gap-free; mismatches %0d",
             mismatches);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver: predicts on every accepted word, then offers the next one
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : drive_words
    text_word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_word(s_tuser, s_tdata);
        words_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (word_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          w = word_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= w.ch;
          s_tuser  <= w.kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result word against the oldest verdict
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_results
    bit want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        strings_checked++;
        if (pending_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result word %h at %0t", m_tdata, $time);
          end
        end else begin
          want = pending_verdicts.pop_front();
          if (m_tdata !== {7'd0, want}) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("string %0d: expected %h got %h at %0t",
                       strings_checked, {7'd0, want}, m_tdata, $time);
            end
          end
          if (m_tdata[0]) begin
            matches_seen++;
          end
        end
      end
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: no word moving on either side for too long
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles, %0d verdicts owed",
                 quiet_cycles, pending_verdicts.size());
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule

@@ files.f @@
sv/mpsm_pkg.sv
sv/mpsm_front.sv
sv/mpsm_queue.sv
sv/mpsm_back.sv
sv/multi_pattern_substring_matcher.sv
sv/mpsm_checker.sv
sim/tb_multi_pattern_substring_matcher.sv
